// ----- rtl/core/dstk_pkg.sv -----
// Data stack package: field widths, operation codes and status codes.
`timescale 1ns / 1ps

package dstk_pkg;

  localparam int unsigned FuncW   = 3;
  localparam int unsigned ValW    = 32;
  localparam int unsigned OffW    = 10;
  localparam int unsigned StatW   = 2;
  localparam int unsigned CountOW = 11;

  localparam logic [FuncW-1:0] FUNC_PUSH = 3'd0;
  localparam logic [FuncW-1:0] FUNC_POP  = 3'd1;
  localparam logic [FuncW-1:0] FUNC_DUP  = 3'd2;
  localparam logic [FuncW-1:0] FUNC_SWAP = 3'd3;
  localparam logic [FuncW-1:0] FUNC_ROT  = 3'd4;
  localparam logic [FuncW-1:0] FUNC_PEEK = 3'd5;

  localparam logic [StatW-1:0] STAT_OK    = 2'd0;
  localparam logic [StatW-1:0] STAT_UNDER = 2'd1;
  localparam logic [StatW-1:0] STAT_OVER  = 2'd2;

endpackage

// ----- rtl/core/data_stack_with_dup_swap_rot.sv -----
// Top level of the bounded data stack with push, pop, dup, swap, rot and peek.
`timescale 1ns / 1ps

// Bounded LIFO stack held in one single-port RAM; every transaction gives one
// result, shown for exactly one cycle with done_o, in the cycle right after the
// last cycle of the operation, which is the first cycle with busy low again (the
// receiver cannot stall it). The single RAM port does one access per cycle, which
// sets how long an operation holds the block: push and any failed or unused op
// finishes in its start cycle; pop and peek read one entry, dup copies the top,
// swap and rot read two or three entries and write them back reordered; a failed
// operation leaves the stack unchanged. entry_count_o is the count after it.
module data_stack_with_dup_swap_rot
  import dstk_pkg::*;
#(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [FuncW-1:0]   func_i,
  input  logic [ValW-1:0]    push_value_i,
  input  logic [OffW-1:0]    peek_offset_i,
  output logic               done_o,
  output logic [ValW-1:0]    read_value_o,
  output logic [StatW-1:0]   status_o,
  output logic [CountOW-1:0] entry_count_o
);

  localparam int unsigned AW   = $clog2(DEPTH);
  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned MAXW = (WIDTH > ValW) ? WIDTH : ValW;
  localparam int unsigned MAXC = (CW > CountOW) ? CW : CountOW;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;

  logic [1:0]       state_q, state_d;
  logic [2:0]       step_q, step_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             done_q, done_d;
  logic [FuncW-1:0] op_q, op_d;
  logic [WIDTH-1:0] tmp_a_q, tmp_a_d, tmp_b_q, tmp_b_d;
  logic [ValW-1:0]  value_q, value_d;
  logic [StatW-1:0] status_q, status_d;

  logic             mem_we;
  logic [AW-1:0]    mem_addr;
  logic [WIDTH-1:0] mem_wdata, rd_word;

  logic [MAXW-1:0]  push_ext, rd_ext;
  logic [WIDTH-1:0] push_word;
  logic [ValW-1:0]  rd_value;
  logic [MAXC-1:0]  cnt_ext, off_ext, peek_idx;
  logic [CW-1:0]    cnt_m1, cnt_m2, cnt_m3;
  logic [AW-1:0]    top1, top2, top3, cnt_addr, peek_addr;
  logic             empty, full, lt2, lt3, peek_ok;

  dstk_ram #(
    .WIDTH(WIDTH),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .addr_i (mem_addr),
    .wdata_i(mem_wdata),
    .rdata_o(rd_word)
  );

  assign push_ext  = MAXW'(push_value_i);
  assign push_word = push_ext[WIDTH-1:0];
  assign rd_ext    = MAXW'(rd_word);
  assign rd_value  = rd_ext[ValW-1:0];

  assign cnt_ext   = MAXC'(cnt_q);
  assign off_ext   = MAXC'(peek_offset_i);
  assign peek_idx  = cnt_ext - off_ext - MAXC'(1);
  assign peek_addr = peek_idx[AW-1:0];
  assign cnt_m1    = cnt_q - CW'(1);
  assign cnt_m2    = cnt_q - CW'(2);
  assign cnt_m3    = cnt_q - CW'(3);
  assign top1      = cnt_m1[AW-1:0];
  assign top2      = cnt_m2[AW-1:0];
  assign top3      = cnt_m3[AW-1:0];
  assign cnt_addr  = cnt_q[AW-1:0];

  assign empty   = (cnt_q == '0);
  assign full    = (cnt_q == CW'(DEPTH));
  assign lt2     = (cnt_q < CW'(2));
  assign lt3     = (cnt_q < CW'(3));
  assign peek_ok = (off_ext < cnt_ext);

  always_comb begin
    state_d   = state_q;
    step_d    = step_q;
    cnt_d     = cnt_q;
    done_d    = 1'b0;
    op_d      = op_q;
    tmp_a_d   = tmp_a_q;
    tmp_b_d   = tmp_b_q;
    value_d   = value_q;
    status_d  = status_q;
    mem_we    = 1'b0;
    mem_addr  = top1;
    mem_wdata = rd_word;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          op_d     = func_i;
          step_d   = 3'd1;
          value_d  = '0;
          status_d = STAT_OK;
          unique case (func_i)
            FUNC_PUSH: begin
              done_d = 1'b1;
              if (full) begin
                status_d = STAT_OVER;
              end else begin
                mem_we    = 1'b1;
                mem_addr  = cnt_addr;
                mem_wdata = push_word;
                cnt_d     = cnt_q + CW'(1);
              end
            end
            FUNC_POP: begin
              if (empty) begin
                status_d = STAT_UNDER;
                done_d   = 1'b1;
              end else begin
                state_d = S_RUN;
              end
            end
            FUNC_DUP: begin
              if (empty) begin
                status_d = STAT_UNDER;
                done_d   = 1'b1;
              end else if (full) begin
                status_d = STAT_OVER;
                done_d   = 1'b1;
              end else begin
                state_d = S_RUN;
              end
            end
            FUNC_SWAP: begin
              if (lt2) begin
                status_d = STAT_UNDER;
                done_d   = 1'b1;
              end else begin
                state_d = S_RUN;
              end
            end
            FUNC_ROT: begin
              if (lt3) begin
                status_d = STAT_UNDER;
                done_d   = 1'b1;
              end else begin
                state_d = S_RUN;
              end
            end
            FUNC_PEEK: begin
              if (!peek_ok) begin
                status_d = STAT_UNDER;
                done_d   = 1'b1;
              end else begin
                mem_addr = peek_addr;
                state_d  = S_RUN;
              end
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end
      S_RUN: begin
        unique case (op_q)
          FUNC_POP: begin
            value_d = rd_value;
            cnt_d   = cnt_m1;
            done_d  = 1'b1;
            state_d = S_IDLE;
          end
          FUNC_PEEK: begin
            value_d = rd_value;
            done_d  = 1'b1;
            state_d = S_IDLE;
          end
          FUNC_DUP: begin
            mem_we   = 1'b1;
            mem_addr = cnt_addr;
            cnt_d    = cnt_q + CW'(1);
            done_d   = 1'b1;
            state_d  = S_IDLE;
          end
          FUNC_SWAP: begin
            if (step_q == 3'd1) begin
              tmp_a_d  = rd_word;
              mem_addr = top2;
              step_d   = 3'd2;
            end else if (step_q == 3'd2) begin
              mem_we   = 1'b1;
              mem_addr = top1;
              step_d   = 3'd3;
            end else begin
              mem_we    = 1'b1;
              mem_addr  = top2;
              mem_wdata = tmp_a_q;
              done_d    = 1'b1;
              state_d   = S_IDLE;
            end
          end
          FUNC_ROT: begin
            if (step_q == 3'd1) begin
              tmp_a_d  = rd_word;
              mem_addr = top2;
              step_d   = 3'd2;
            end else if (step_q == 3'd2) begin
              tmp_b_d  = rd_word;
              mem_addr = top3;
              step_d   = 3'd3;
            end else if (step_q == 3'd3) begin
              mem_we   = 1'b1;
              mem_addr = top1;
              step_d   = 3'd4;
            end else if (step_q == 3'd4) begin
              mem_we    = 1'b1;
              mem_addr  = top2;
              mem_wdata = tmp_a_q;
              step_d    = 3'd5;
            end else begin
              mem_we    = 1'b1;
              mem_addr  = top3;
              mem_wdata = tmp_b_q;
              done_d    = 1'b1;
              state_d   = S_IDLE;
            end
          end
          default: begin
            done_d  = 1'b1;
            state_d = S_IDLE;
          end
        endcase
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= '0;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    tmp_a_q  <= tmp_a_d;
    tmp_b_q  <= tmp_b_d;
    value_q  <= value_d;
    status_q <= status_d;
  end

  assign busy          = (state_q != S_IDLE);
  assign done_o        = done_q;
  assign read_value_o  = value_q;
  assign status_o      = status_q;
  assign entry_count_o = cnt_ext[CountOW-1:0];

endmodule

// ----- rtl/core/dstk_ram.sv -----
// Single-port synchronous RAM with registered read data.
`timescale 1ns / 1ps

module dstk_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the data stack: directed, full-stack and random transactions.
`timescale 1ns / 1ps

module testbench;
  import dstk_pkg::*;

  localparam int unsigned Depth      = 1024;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned RandomOps  = 60;
  localparam int unsigned DrainWait  = 20;

  localparam logic [FuncW-1:0] FUNC_SPARE6 = 3'd6;
  localparam logic [FuncW-1:0] FUNC_SPARE7 = 3'd7;

  typedef struct packed {
    logic [ValW-1:0]    read_value;
    logic [StatW-1:0]   status;
    logic [CountOW-1:0] entry_count;
  } stack_reply_t;

  logic               clk         = 1'b0;
  logic               rst_n       = 1'b0;
  logic               start       = 1'b0;
  logic [FuncW-1:0]   func        = FUNC_PUSH;
  logic [ValW-1:0]    push_value  = '0;
  logic [OffW-1:0]    peek_offset = '0;
  logic               busy;
  logic               done;
  logic [ValW-1:0]    read_value;
  logic [StatW-1:0]   status;
  logic [CountOW-1:0] entry_count;

  logic [ValW-1:0] shadow_mem [Depth];
  int unsigned     shadow_fill = 0;
  stack_reply_t    pending_replies [$];
  int unsigned     errors  = 0;
  int unsigned     cycles  = 0;
  bit              no_idle = 1'b0;

  data_stack_with_dup_swap_rot #(
    .DEPTH(Depth),
    .WIDTH(ValW)
  ) uut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .start        (start),
    .busy         (busy),
    .func_i       (func),
    .push_value_i (push_value),
    .peek_offset_i(peek_offset),
    .done_o       (done),
    .read_value_o (read_value),
    .status_o     (status),
    .entry_count_o(entry_count)
  );

  always #2 clk = ~clk;

  // shadow stack: applies one transaction and returns the reply it should give
  function automatic stack_reply_t apply_stack_op(input logic [FuncW-1:0] op,
                                                  input logic [ValW-1:0] val,
                                                  input logic [OffW-1:0] off);
    stack_reply_t    r;
    logic [ValW-1:0] a;
    logic [ValW-1:0] b;
    logic [ValW-1:0] c;
    r.read_value = '0;
    r.status     = STAT_OK;
    case (op)
      FUNC_PUSH: begin
        if (shadow_fill >= Depth) begin
          r.status = STAT_OVER;
        end else begin
          shadow_mem[shadow_fill] = val;
          shadow_fill++;
        end
      end
      FUNC_POP: begin
        if (shadow_fill == 0) begin
          r.status = STAT_UNDER;
        end else begin
          r.read_value = shadow_mem[shadow_fill-1];
          shadow_fill--;
        end
      end
      FUNC_DUP: begin
        if (shadow_fill == 0) begin
          r.status = STAT_UNDER;
        end else if (shadow_fill >= Depth) begin
          r.status = STAT_OVER;
        end else begin
          shadow_mem[shadow_fill] = shadow_mem[shadow_fill-1];
          shadow_fill++;
        end
      end
      FUNC_SWAP: begin
        if (shadow_fill < 2) begin
          r.status = STAT_UNDER;
        end else begin
          a = shadow_mem[shadow_fill-1];
          b = shadow_mem[shadow_fill-2];
          shadow_mem[shadow_fill-1] = b;
          shadow_mem[shadow_fill-2] = a;
        end
      end
      FUNC_ROT: begin
        if (shadow_fill < 3) begin
          r.status = STAT_UNDER;
        end else begin
          a = shadow_mem[shadow_fill-1];
          b = shadow_mem[shadow_fill-2];
          c = shadow_mem[shadow_fill-3];
          shadow_mem[shadow_fill-1] = c;
          shadow_mem[shadow_fill-2] = a;
          shadow_mem[shadow_fill-3] = b;
        end
      end
      FUNC_PEEK: begin
        if (off >= shadow_fill) begin
          r.status = STAT_UNDER;
        end else begin
          r.read_value = shadow_mem[shadow_fill-1-off];
        end
      end
      default: begin
      end
    endcase
    r.entry_count = shadow_fill[CountOW-1:0];
    return r;
  endfunction

  function automatic logic [OffW-1:0] rand_off(input int unsigned hi);
    return OffW'($urandom_range(0, hi));
  endfunction

  task automatic send_op(input logic [FuncW-1:0] op, input logic [ValW-1:0] val,
                         input logic [OffW-1:0] off);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 14);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start       <= 1'b1;
    func        <= op;
    push_value  <= val;
    peek_offset <= off;
    do @(posedge clk); while (busy);
    pending_replies.push_back(apply_stack_op(op, val, off));
  endtask

  task automatic test_edge_ops();
    send_op(FUNC_POP, $urandom, rand_off(1023));
    send_op(FUNC_DUP, $urandom, rand_off(1023));
    send_op(FUNC_SWAP, $urandom, rand_off(1023));
    send_op(FUNC_ROT, $urandom, rand_off(1023));
    send_op(FUNC_PEEK, $urandom, '0);
    send_op(FUNC_SPARE6, $urandom, rand_off(1023));
    send_op(FUNC_SPARE7, $urandom, rand_off(1023));
    send_op(FUNC_PUSH, '0, '1);
    send_op(FUNC_SWAP, $urandom, rand_off(1023));
    send_op(FUNC_PEEK, $urandom, 10'd1);
    send_op(FUNC_PUSH, '1, '0);
    send_op(FUNC_ROT, $urandom, rand_off(1023));
    send_op(FUNC_SWAP, $urandom, rand_off(1023));
    send_op(FUNC_PUSH, 32'h8000_0001, rand_off(1023));
    send_op(FUNC_ROT, $urandom, rand_off(1023));
    send_op(FUNC_DUP, $urandom, rand_off(1023));
    send_op(FUNC_PEEK, $urandom, 10'd0);
    send_op(FUNC_PEEK, $urandom, 10'd3);
    send_op(FUNC_PEEK, $urandom, 10'd4);
    send_op(FUNC_PEEK, $urandom, '1);
    repeat (5) send_op(FUNC_POP, $urandom, rand_off(1023));
  endtask

  task automatic test_full_stack();
    no_idle = 1'b1;
    while (shadow_fill < Depth) begin
      if ($urandom_range(0, 15) == 0)
        send_op(FUNC_DUP, $urandom, rand_off(1023));
      else
        send_op(FUNC_PUSH, $urandom, rand_off(1023));
    end
    no_idle = 1'b0;
    send_op(FUNC_PUSH, $urandom, rand_off(1023));
    send_op(FUNC_DUP, $urandom, rand_off(1023));
    send_op(FUNC_PEEK, $urandom, '1);
    send_op(FUNC_PEEK, $urandom, '0);
    send_op(FUNC_SWAP, $urandom, rand_off(1023));
    send_op(FUNC_ROT, $urandom, rand_off(1023));
    send_op(FUNC_POP, $urandom, rand_off(1023));
    send_op(FUNC_DUP, $urandom, rand_off(1023));
    send_op(FUNC_DUP, $urandom, rand_off(1023));
    // spot checks deep in the full stack
    repeat (8) send_op(FUNC_PEEK, $urandom, rand_off(shadow_fill - 1));
  endtask

  task automatic test_random_mix();
    int unsigned     pick;
    logic [FuncW-1:0] op;
    logic [ValW-1:0]  val;
    logic [OffW-1:0]  off;
    for (int unsigned i = 0; i < RandomOps; i++) begin
      if (i % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 28)      op = FUNC_PUSH;
      else if (pick < 36) op = FUNC_DUP;
      else if (pick < 61) op = FUNC_POP;
      else if (pick < 72) op = FUNC_SWAP;
      else if (pick < 84) op = FUNC_ROT;
      else if (pick < 97) op = FUNC_PEEK;
      else                op = $urandom_range(0, 1) ? FUNC_SPARE6 : FUNC_SPARE7;
      case ($urandom_range(0, 9))
        0: val = '0;
        1: val = '1;
        default: val = $urandom;
      endcase
      if (shadow_fill > 0 && $urandom_range(0, 3) != 0)
        off = rand_off(shadow_fill - 1);
      else
        off = rand_off(1023);
      send_op(op, val, off);
    end
    no_idle = 1'b0;
  endtask

  always @(posedge clk) begin : reply_check
    stack_reply_t want;
    if (rst_n && done === 1'b1) begin
      if (pending_replies.size() == 0) begin
        $error("result with no transaction outstanding");
        errors++;
      end else begin
        want = pending_replies.pop_front();
        if (read_value !== want.read_value) begin
          $error("read_value: expected %h, got %h", want.read_value, read_value);
          errors++;
        end
        if (status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status);
          errors++;
        end
        if (entry_count !== want.entry_count) begin
          $error("entry_count: expected %0d, got %0d", want.entry_count, entry_count);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);
    test_edge_ops();
    test_random_mix();
    test_full_stack();
    start <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
    if (errors == 0 && pending_replies.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
